>>> rtl/rc_pulse_width_capture_macros.svh
// Assertion macros for the RC pulse width capture block.
// Used by the block's RTL files; expects a clk and rst signal in scope.
`ifndef RC_PULSE_WIDTH_CAPTURE_MACROS_SVH
`define RC_PULSE_WIDTH_CAPTURE_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define RPWC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define RPWC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/rpwc_pkg.sv
// Shared types and constants for the RC pulse width capture block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rpwc_pkg;

  localparam int CH_COUNT     = 4;
  localparam int LEVEL_W      = 4;
  localparam int WIDTH_W      = 12;
  localparam int STAMP_W      = 16;
  localparam int MS_W         = 16;
  localparam int TIMEOUT_W    = 16;
  localparam int TICKS_PER_MS = 1000;
  localparam int PRESC_W      = $clog2(TICKS_PER_MS + 1);

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;

  // Reset values of the configuration registers
  localparam logic [WIDTH_W-1:0]   ACCEPT_MIN_RESET = 12'd800;
  localparam logic [WIDTH_W-1:0]   ACCEPT_MAX_RESET = 12'd2200;
  localparam logic [WIDTH_W-1:0]   CLAMP_MIN_RESET  = 12'd1000;
  localparam logic [WIDTH_W-1:0]   CLAMP_MAX_RESET  = 12'd2000;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET    = 16'd500;

  // Held width after reset
  localparam logic [WIDTH_W-1:0] HELD_THROTTLE_RESET = 12'd1000;
  localparam logic [WIDTH_W-1:0] HELD_OTHER_RESET    = 12'd1500;

  // Register indexes (word address)
  typedef enum logic [2:0] {
    REG_ACCEPT_MIN = 3'd0,
    REG_ACCEPT_MAX = 3'd1,
    REG_CLAMP_MIN  = 3'd2,
    REG_CLAMP_MAX  = 3'd3,
    REG_TIMEOUT    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [WIDTH_W-1:0]   accept_min_us;
    logic [WIDTH_W-1:0]   accept_max_us;
    logic [WIDTH_W-1:0]   clamp_min_us;
    logic [WIDTH_W-1:0]   clamp_max_us;
    logic [TIMEOUT_W-1:0] fs_timeout_ms;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/rc_pulse_width_capture.sv
// Four-channel RC pulse width capture, one tick per transfer.
// Each pin_levels transfer passes through the input register and then the result register.
// Throughput: one tick per cycle; the result register and input register each
// hold one tick, so a stalled output stops input only when both are full.
// Reset (rst, synchronous): clears timers, stamps, edges; held widths to defaults.
`timescale 1ns / 1ps
`default_nettype none

module rc_pulse_width_capture import rpwc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  pin_valid,
  output logic                       pin_ready,
  input  wire logic [LEVEL_W-1:0]    pin_levels,
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output logic      [WIDTH_W-1:0]    throttle_us,
  output logic      [WIDTH_W-1:0]    pitch_us,
  output logic      [WIDTH_W-1:0]    roll_us,
  output logic      [WIDTH_W-1:0]    yaw_us,
  output logic                       failsafe,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  `include "rc_pulse_width_capture_macros.svh"

  cfg_t                          cfg;
  logic                          in_reg_valid;
  logic [LEVEL_W-1:0]            in_levels;
  logic [LEVEL_W-1:0]            previous_levels;
  logic                          step;
  logic [STAMP_W-1:0]            stamp;
  logic [CH_COUNT-1:0]           accepted;
  logic [CH_COUNT-1:0][WIDTH_W-1:0] width_us;
  logic [CH_COUNT-1:0][WIDTH_W-1:0] held_reset;
  logic                          failsafe_now;

  // Process the input register when the result register is free or draining
  assign step      = in_reg_valid && (!result_valid || result_ready);
  assign pin_ready = !in_reg_valid || step;

  rpwc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rpwc_timer u_timer (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .valid_seen (|accepted),
    .timeout_ms (cfg.fs_timeout_ms),
    .stamp      (stamp),
    .failsafe   (failsafe_now)
  );

  // Throttle starts at its own default
  assign held_reset[0] = HELD_THROTTLE_RESET;
  assign held_reset[1] = HELD_OTHER_RESET;
  assign held_reset[2] = HELD_OTHER_RESET;
  assign held_reset[3] = HELD_OTHER_RESET;

  for (genvar c = 0; c < CH_COUNT; c++) begin : g_ch
    rpwc_channel u_channel (
      .clk        (clk),
      .rst        (rst),
      .step       (step),
      .level      (in_levels[c]),
      .prev_level (previous_levels[c]),
      .stamp      (stamp),
      .held_reset (held_reset[c]),
      .cfg        (cfg),
      .accepted   (accepted[c]),
      .width_us   (width_us[c])
    );
  end

  // Input register and previous levels
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid    <= 1'b0;
      previous_levels <= '0;
    end else begin
      if (pin_valid && pin_ready) begin
        in_reg_valid <= 1'b1;
      end else if (step) begin
        in_reg_valid <= 1'b0;
      end
      if (step) begin
        previous_levels <= in_levels;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pin_valid && pin_ready) begin
      in_levels <= pin_levels;
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (step) begin
      throttle_us <= width_us[0];
      pitch_us    <= width_us[1];
      roll_us     <= width_us[2];
      yaw_us      <= width_us[3];
      failsafe    <= failsafe_now;
    end
  end

  `RPWC_ASSERT(a_stall_cause, !pin_ready |-> (in_reg_valid && result_valid && !result_ready),
    "input stalled without a full pipeline")
  `RPWC_ASSERT_NEXT(a_step_result, step, result_valid, "processed tick not presented")
  `RPWC_ASSERT_NEXT(a_prev_levels, step, previous_levels == $past(in_levels),
    "previous levels not advanced")

endmodule

`default_nettype wire

>>> rtl/rpwc_regs.sv
// APB configuration registers of the RC pulse width capture block.
// Depends on rpwc_pkg for register indexes and the config struct.
`timescale 1ns / 1ps
`default_nettype none

module rpwc_regs import rpwc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  logic       wr_en;
  logic [2:0] word_idx;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign word_idx = paddr[APB_ADDR_W-1:2];

  // Write registers on the access phase of a write transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accept_min_us <= ACCEPT_MIN_RESET;
      cfg.accept_max_us <= ACCEPT_MAX_RESET;
      cfg.clamp_min_us  <= CLAMP_MIN_RESET;
      cfg.clamp_max_us  <= CLAMP_MAX_RESET;
      cfg.fs_timeout_ms <= TIMEOUT_RESET;
    end else if (wr_en) begin
      unique case (word_idx)
        REG_ACCEPT_MIN: cfg.accept_min_us <= pwdata[WIDTH_W-1:0];
        REG_ACCEPT_MAX: cfg.accept_max_us <= pwdata[WIDTH_W-1:0];
        REG_CLAMP_MIN:  cfg.clamp_min_us  <= pwdata[WIDTH_W-1:0];
        REG_CLAMP_MAX:  cfg.clamp_max_us  <= pwdata[WIDTH_W-1:0];
        REG_TIMEOUT:    cfg.fs_timeout_ms <= pwdata[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    prdata = '0;
    unique case (word_idx)
      REG_ACCEPT_MIN: prdata = APB_DATA_W'(cfg.accept_min_us);
      REG_ACCEPT_MAX: prdata = APB_DATA_W'(cfg.accept_max_us);
      REG_CLAMP_MIN:  prdata = APB_DATA_W'(cfg.clamp_min_us);
      REG_CLAMP_MAX:  prdata = APB_DATA_W'(cfg.clamp_max_us);
      REG_TIMEOUT:    prdata = APB_DATA_W'(cfg.fs_timeout_ms);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/rpwc_channel.sv
// One channel of the pulse decoder: edge handling, width check, hold and clamp.
// Depends on rpwc_pkg; instantiated once per channel by the top level.
`timescale 1ns / 1ps
`default_nettype none

module rpwc_channel import rpwc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire logic               level,
  input  wire logic               prev_level,
  input  wire logic [STAMP_W-1:0] stamp,
  input  wire logic [WIDTH_W-1:0] held_reset,
  input  wire cfg_t               cfg,
  output logic                    accepted,
  output logic      [WIDTH_W-1:0] width_us
);

  `include "rc_pulse_width_capture_macros.svh"

  logic [STAMP_W-1:0] rise_stamp;
  logic [WIDTH_W-1:0] held_width;
  logic [WIDTH_W-1:0] held_width_next;
  logic [STAMP_W-1:0] width_raw;
  logic               rise;
  logic               fall;
  logic               in_window;

  assign rise = step && level && !prev_level;
  assign fall = step && !level && prev_level;

  // Measure the pulse modulo the stamp width and check the accept window
  assign width_raw = stamp - rise_stamp;
  assign in_window = (width_raw >= STAMP_W'(cfg.accept_min_us)) &&
                     (width_raw <= STAMP_W'(cfg.accept_max_us));
  assign accepted  = fall && in_window;

  assign held_width_next = accepted ? width_raw[WIDTH_W-1:0] : held_width;

  // Clamp the updated held width to the output limits
  always_comb begin
    if (held_width_next < cfg.clamp_min_us) begin
      width_us = cfg.clamp_min_us;
    end else if (held_width_next > cfg.clamp_max_us) begin
      width_us = cfg.clamp_max_us;
    end else begin
      width_us = held_width_next;
    end
  end

  // Hold rise stamp and accepted width
  always_ff @(posedge clk) begin
    if (rst) begin
      rise_stamp <= '0;
      held_width <= held_reset;
    end else begin
      if (rise) begin
        rise_stamp <= stamp;
      end
      held_width <= held_width_next;
    end
  end

  `RPWC_ASSERT(a_edge_excl, !(rise && fall), "rise and fall in the same tick")
  `RPWC_ASSERT_NEXT(a_held_in_window, accepted,
    (held_width >= $past(cfg.accept_min_us)) && (held_width <= $past(cfg.accept_max_us)),
    "held width outside accept window")
  `RPWC_ASSERT_NEXT(a_rise_stamp, rise, rise_stamp == $past(stamp),
    "rise stamp not captured")

endmodule

`default_nettype wire

>>> rtl/rpwc_timer.sv
// Microsecond stamp, millisecond prescaler and since-valid counter.
// Depends on rpwc_pkg; produces the stamp and the failsafe flag per tick.
`timescale 1ns / 1ps
`default_nettype none

module rpwc_timer import rpwc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire logic                 valid_seen,
  input  wire logic [TIMEOUT_W-1:0] timeout_ms,
  output logic      [STAMP_W-1:0]   stamp,
  output logic                      failsafe
);

  `include "rc_pulse_width_capture_macros.svh"

  localparam logic [PRESC_W-1:0] PRESC_LAST = PRESC_W'(TICKS_PER_MS - 1);
  localparam logic [MS_W-1:0]    MS_MAX     = '1;

  logic [PRESC_W-1:0] ms_prescaler;
  logic [MS_W-1:0]    ms_since_valid;
  logic [MS_W-1:0]    ms_cleared;

  // Clear on a valid pulse before the flag is formed
  assign ms_cleared = valid_seen ? '0 : ms_since_valid;
  assign failsafe   = ms_cleared > timeout_ms;

  // Advance stamp and prescaler; count milliseconds with saturation
  always_ff @(posedge clk) begin
    if (rst) begin
      stamp          <= '0;
      ms_prescaler   <= '0;
      ms_since_valid <= '0;
    end else if (step) begin
      stamp <= stamp + STAMP_W'(1);
      if (ms_prescaler == PRESC_LAST) begin
        ms_prescaler <= '0;
        ms_since_valid <= (ms_cleared == MS_MAX) ? MS_MAX : ms_cleared + MS_W'(1);
      end else begin
        ms_prescaler   <= ms_prescaler + PRESC_W'(1);
        ms_since_valid <= ms_cleared;
      end
    end
  end

  `RPWC_ASSERT(a_presc_range, ms_prescaler <= PRESC_LAST, "prescaler out of range")
  `RPWC_ASSERT_NEXT(a_valid_clears, step && valid_seen, ms_since_valid <= MS_W'(1),
    "valid pulse did not clear the counter")
  `RPWC_ASSERT_NEXT(a_stamp_hold, !step, stamp == $past(stamp),
    "stamp moved without a tick")

endmodule

`default_nettype wire

>>> sim/tb_rc_pulse_width_capture.sv
// Self-checking testbench for rc_pulse_width_capture: directed ticks, then random pulse trains.
// Depends on rpwc_pkg and the rc_pulse_width_capture RTL; needs no other file.
`timescale 1ns / 1ps

module tb_rc_pulse_width_capture;
  import rpwc_pkg::*;

  typedef struct packed {
    logic [WIDTH_W-1:0] throttle_us;
    logic [WIDTH_W-1:0] pitch_us;
    logic [WIDTH_W-1:0] roll_us;
    logic [WIDTH_W-1:0] yaw_us;
    logic               failsafe;
  } servo_out_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] levels;
    logic               typed;
    servo_out_t         outs;
  } tick_row_t;

  // Outputs right after reset with the default limits
  localparam servo_out_t RESET_OUT = '{HELD_THROTTLE_RESET, HELD_OTHER_RESET,
                                       HELD_OTHER_RESET, HELD_OTHER_RESET, 1'b0};
  localparam int DIRECTED_ROWS = 22;

  logic                  clk;
  logic                  rst;
  logic                  pin_valid;
  logic                  pin_ready;
  logic [LEVEL_W-1:0]    pin_levels;
  logic                  result_valid;
  logic                  result_ready;
  logic [WIDTH_W-1:0]    throttle_us;
  logic [WIDTH_W-1:0]    pitch_us;
  logic [WIDTH_W-1:0]    roll_us;
  logic [WIDTH_W-1:0]    yaw_us;
  logic                  failsafe;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Shadow of the block: configuration and decoder state
  cfg_t               cfg_shadow;
  logic [LEVEL_W-1:0] last_levels;
  logic [STAMP_W-1:0] us_stamp;
  logic [STAMP_W-1:0] rise_at [CH_COUNT];
  logic [WIDTH_W-1:0] held [CH_COUNT];
  logic [9:0]         presc_cnt;
  logic [MS_W-1:0]    ms_idle;

  servo_out_t pending_outs [$];
  int         err_cnt;
  bit         idle_on;
  int         stall_left;
  bit         row_typed;
  servo_out_t row_outs;

  // First tick raises all pins (rising edge from the reset levels), then single
  // pins, all-low and all-high; widths stay far below the default accept window
  tick_row_t directed_rows [DIRECTED_ROWS] = '{
    '{4'hF, 1'b1, RESET_OUT}, '{4'h0, 1'b1, RESET_OUT}, '{4'h1, 1'b1, RESET_OUT},
    '{4'h2, 1'b0, RESET_OUT}, '{4'h4, 1'b0, RESET_OUT}, '{4'h8, 1'b0, RESET_OUT},
    '{4'hF, 1'b1, RESET_OUT}, '{4'hF, 1'b1, RESET_OUT}, '{4'hE, 1'b0, RESET_OUT},
    '{4'hD, 1'b0, RESET_OUT}, '{4'hB, 1'b0, RESET_OUT}, '{4'h7, 1'b0, RESET_OUT},
    '{4'h0, 1'b1, RESET_OUT}, '{4'h5, 1'b0, RESET_OUT}, '{4'hA, 1'b0, RESET_OUT},
    '{4'hF, 1'b0, RESET_OUT}, '{4'h0, 1'b1, RESET_OUT}, '{4'h3, 1'b0, RESET_OUT},
    '{4'hC, 1'b0, RESET_OUT}, '{4'h9, 1'b0, RESET_OUT}, '{4'h6, 1'b0, RESET_OUT},
    '{4'h0, 1'b1, RESET_OUT}
  };

  rc_pulse_width_capture i_dut (
    .clk          (clk),
    .rst          (rst),
    .pin_valid    (pin_valid),
    .pin_ready    (pin_ready),
    .pin_levels   (pin_levels),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .throttle_us  (throttle_us),
    .pitch_us     (pitch_us),
    .roll_us      (roll_us),
    .yaw_us       (yaw_us),
    .failsafe     (failsafe),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // Print a mismatch line (only for the first 40) and count every mismatch
  task automatic flag_mismatch(input string what, input int exp_val, input int got_val);
    if (err_cnt < 40) begin
      $display("MISMATCH %s: expected %0d, got %0d at %0t", what, exp_val, got_val, $realtime);
    end
    err_cnt++;
  endtask

  function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] w);
    if (w < cfg_shadow.clamp_min_us) return cfg_shadow.clamp_min_us;
    if (w > cfg_shadow.clamp_max_us) return cfg_shadow.clamp_max_us;
    return w;
  endfunction

  // Decode one microsecond tick: edges use the stamp before it advances
  function automatic servo_out_t decode_tick(input logic [LEVEL_W-1:0] lv);
    logic [LEVEL_W-1:0] flips;
    logic [STAMP_W-1:0] w;
    logic               fresh;
    servo_out_t         o;
    flips = lv ^ last_levels;
    fresh = 1'b0;
    for (int c = 0; c < CH_COUNT; c++) begin
      if (flips[c]) begin
        if (lv[c]) begin
          rise_at[c] = us_stamp;
        end else begin
          w = us_stamp - rise_at[c];
          if (w >= cfg_shadow.accept_min_us && w <= cfg_shadow.accept_max_us) begin
            held[c] = w[WIDTH_W-1:0];
            fresh = 1'b1;
          end
        end
      end
    end
    last_levels = lv;
    if (fresh) ms_idle = '0;
    o.throttle_us = clamp_width(held[0]);
    o.pitch_us    = clamp_width(held[1]);
    o.roll_us     = clamp_width(held[2]);
    o.yaw_us      = clamp_width(held[3]);
    o.failsafe    = ms_idle > cfg_shadow.fs_timeout_ms;
    // advance stamp, prescaler and saturating ms counter
    us_stamp  = us_stamp + 1'b1;
    presc_cnt = presc_cnt + 1'b1;
    if (presc_cnt >= TICKS_PER_MS) begin
      presc_cnt = '0;
      if (ms_idle != '1) ms_idle = ms_idle + 1'b1;
    end
    return o;
  endfunction

  // Predict on each input transfer, check each result transfer
  always @(posedge clk) begin
    servo_out_t exp_o;
    if (!rst) begin
      if (pin_valid && pin_ready) begin
        exp_o = decode_tick(pin_levels);
        if (row_typed) exp_o = row_outs;
        pending_outs.push_back(exp_o);
      end
      if (result_valid && result_ready) begin
        if (pending_outs.size() == 0) begin
          flag_mismatch("unexpected result transfer", 0, 1);
        end else begin
          exp_o = pending_outs.pop_front();
          if (throttle_us !== exp_o.throttle_us)
            flag_mismatch("throttle_us", exp_o.throttle_us, throttle_us);
          if (pitch_us !== exp_o.pitch_us)
            flag_mismatch("pitch_us", exp_o.pitch_us, pitch_us);
          if (roll_us !== exp_o.roll_us)
            flag_mismatch("roll_us", exp_o.roll_us, roll_us);
          if (yaw_us !== exp_o.yaw_us)
            flag_mismatch("yaw_us", exp_o.yaw_us, yaw_us);
          if (failsafe !== exp_o.failsafe)
            flag_mismatch("failsafe", exp_o.failsafe, failsafe);
        end
      end
    end
  end

  // Stall the result side in random bursts, started only while idle_on is set
  always @(negedge clk) begin
    if (stall_left != 0) begin
      result_ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      result_ready <= 1'b0;
      stall_left   <= $urandom_range(0, 6);
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Send one tick; entered and left at a falling edge
  task automatic send_tick(input logic [LEVEL_W-1:0] lv, input bit typed,
                           input servo_out_t outs);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      pin_valid  <= 1'b0;
      pin_levels <= LEVEL_W'($urandom);
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    row_typed  = typed;
    row_outs   = outs;
    pin_valid  <= 1'b1;
    pin_levels <= lv;
    do @(posedge clk); while (!pin_ready);
    @(negedge clk);
  endtask

  // Drop valid and wait until every tick has produced its result
  task automatic drain_results();
    pin_valid <= 1'b0;
    row_typed = 1'b0;
    while (pending_outs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write a register, read it back and update the shadow copy
  task automatic cfg_set(input reg_idx_t idx, input logic [APB_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== val) flag_mismatch("register read back", val, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_ACCEPT_MIN: cfg_shadow.accept_min_us = val[WIDTH_W-1:0];
      REG_ACCEPT_MAX: cfg_shadow.accept_max_us = val[WIDTH_W-1:0];
      REG_CLAMP_MIN:  cfg_shadow.clamp_min_us  = val[WIDTH_W-1:0];
      REG_CLAMP_MAX:  cfg_shadow.clamp_max_us  = val[WIDTH_W-1:0];
      REG_TIMEOUT:    cfg_shadow.fs_timeout_ms = val[TIMEOUT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_limits(input int amin, input int amax, input int cmin, input int cmax,
                             input int tmo);
    drain_results();
    cfg_set(REG_ACCEPT_MIN, amin);
    cfg_set(REG_ACCEPT_MAX, amax);
    cfg_set(REG_CLAMP_MIN, cmin);
    cfg_set(REG_CLAMP_MAX, cmax);
    cfg_set(REG_TIMEOUT, tmo);
  endtask

  // Random pulse trains per channel, high for hmin..hmax ticks, with some glitch ticks
  task automatic run_pulses(input int n, input int hmin, input int hmax);
    logic [LEVEL_W-1:0] lvl_now;
    logic [LEVEL_W-1:0] drive;
    int                 left [CH_COUNT];
    lvl_now = '0;
    for (int c = 0; c < CH_COUNT; c++) left[c] = $urandom_range(0, 5);
    for (int i = 0; i < n; i++) begin
      for (int c = 0; c < CH_COUNT; c++) begin
        if (left[c] == 0) begin
          lvl_now[c] = ~lvl_now[c];
          left[c]    = lvl_now[c] ? $urandom_range(hmin, hmax) : $urandom_range(1, 12);
        end
        left[c]--;
      end
      drive = ($urandom_range(0, 15) == 0) ? LEVEL_W'($urandom) : lvl_now;
      send_tick(drive, 1'b0, RESET_OUT);
    end
  endtask

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    pin_valid    = 1'b0;
    pin_levels   = '0;
    result_ready = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    err_cnt      = 0;
    idle_on      = 1'b1;
    stall_left   = 0;
    row_typed    = 1'b0;
    row_outs     = RESET_OUT;
    cfg_shadow   = '{ACCEPT_MIN_RESET, ACCEPT_MAX_RESET, CLAMP_MIN_RESET, CLAMP_MAX_RESET,
                     TIMEOUT_RESET};
    last_levels  = '0;
    us_stamp     = '0;
    presc_cnt    = '0;
    ms_idle      = '0;
    for (int c = 0; c < CH_COUNT; c++) begin
      rise_at[c] = '0;
      held[c]    = (c == 0) ? HELD_THROTTLE_RESET : HELD_OTHER_RESET;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed ticks under the reset limits
    foreach (directed_rows[i]) begin
      send_tick(directed_rows[i].levels, directed_rows[i].typed, directed_rows[i].outs);
    end

    // Widest windows and limits, longest timeout
    load_limits(0, 4095, 0, 4095, 65535);
    run_pulses(300, 1, 60);

    // Narrow windows, some pulses rejected
    load_limits(3, 30, 10, 20, 1);
    run_pulses(300, 1, 40);

    // Inverted accept window and clamp; no pulse accepted, so failsafe rises
    load_limits(4095, 0, 25, 12, 0);
    run_pulses(1000, 1, 40);

    // Valid pulses again clear failsafe; no idling from here on
    load_limits(2, 50, 6, 40, 0);
    idle_on = 1'b0;
    run_pulses(330, 1, 60);

    drain_results();
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
